/* hdl/bmrc_pkg.sv */
package bmrc_pkg;

    // fixed field widths
    localparam int CMD_W   = 2;
    localparam int COORD_W = 10;
    localparam int LIT_W   = 21;

    // operation codes
    localparam logic [CMD_W-1:0] OP_SET    = 2'd0;
    localparam logic [CMD_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] OP_INVERT = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic clear_step;
        logic load;
        logic seek_step;
        logic issue;
        logic load_result;
    } bmrc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic in_noop;
        logic seek_done;
        logic word_last;
        logic row_last;
        logic pipe_busy;
    } bmrc_stat_t;

endpackage

/* hdl/bmrc_ctrl.sv */
module bmrc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    output logic                 res_valid,
    input  logic                 res_stall,
    output bmrc_pkg::bmrc_cmd_t  dp_cmd,
    input  bmrc_pkg::bmrc_stat_t stat
);
    import bmrc_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SEEK  = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic       out_free;

    // output register can take a new word
    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        dp_cmd         = '0;
        res_valid_next = res_valid_reg && res_stall;
        unique case (state_reg)
            ST_CLEAR:
            begin
                dp_cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = stat.in_noop ? ST_DRAIN : ST_SEEK;
                end
            end
            ST_SEEK:
            begin
                dp_cmd.seek_step = 1'b1;
                if (stat.seek_done)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                dp_cmd.issue = 1'b1;
                if (stat.word_last && stat.row_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy && out_free)
                begin
                    dp_cmd.load_result = 1'b1;
                    res_valid_next     = 1'b1;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result only taken once every word write has reached the count
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load_result |-> !stat.pipe_busy)
        else $error("result loaded while pipeline busy");

    // an accepted command goes to the word search or straight to drain
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load |=> (state_reg == ST_SEEK) || (state_reg == ST_DRAIN))
        else $error("bad state after command load");

    // last word of last row ends issuing
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.issue && stat.word_last && stat.row_last |=>
            (state_reg == ST_DRAIN) && !dp_cmd.issue)
        else $error("issue continued past last word");

endmodule

/* hdl/bmrc_datapath.sv */
module bmrc_datapath #(
    parameter int GRID_COLUMNS = 1024,
    parameter int GRID_ROWS    = 1024,
    parameter int WORD_BITS    = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [bmrc_pkg::CMD_W-1:0]   command,
    input  logic [bmrc_pkg::COORD_W-1:0] first_column,
    input  logic [bmrc_pkg::COORD_W-1:0] first_row,
    input  logic [bmrc_pkg::COORD_W-1:0] last_column,
    input  logic [bmrc_pkg::COORD_W-1:0] last_row,
    input  bmrc_pkg::bmrc_cmd_t          dp_cmd,
    output bmrc_pkg::bmrc_stat_t         stat,
    output logic [bmrc_pkg::LIT_W-1:0]   lit_count
);
    import bmrc_pkg::*;

    localparam int WORDS_PER_ROW = (GRID_COLUMNS + WORD_BITS - 1) / WORD_BITS;
    localparam int TOTAL_WORDS   = WORDS_PER_ROW * GRID_ROWS;
    localparam int AW            = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int WW            = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
    localparam int SUM_W         = COORD_W + 1;
    localparam int NG            = (WORD_BITS + 7) / 8;
    localparam int GW            = 4;
    localparam int PW            = $clog2(WORD_BITS + 1);

    // bitmap storage
    logic [WORD_BITS-1:0] bitmap_reg [TOTAL_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    // command registers
    logic [CMD_W-1:0]   op_reg;
    logic [COORD_W-1:0] c0_reg;
    logic [COORD_W-1:0] c1_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] r1_reg;
    logic [AW-1:0]      row_base_reg;
    logic [WW-1:0]      word_reg;
    logic [WW-1:0]      word0_reg;
    logic [COORD_W-1:0] base_reg;
    logic [COORD_W-1:0] base0_reg;
    logic [AW-1:0]      clear_addr_reg;

    // pipeline registers
    logic                 s1_valid_reg;
    logic [AW-1:0]        s1_addr_reg;
    logic [WORD_BITS-1:0] s1_mask_reg;
    logic                 s2_valid_reg;
    logic [GW-1:0]        grp_old_reg [NG];
    logic [GW-1:0]        grp_new_reg [NG];
    logic                 s3_valid_reg;
    logic [PW-1:0]        pop_old_reg;
    logic [PW-1:0]        pop_new_reg;
    logic [LIT_W-1:0]     count_reg;
    logic [LIT_W-1:0]     lit_count_reg;

    // combinational signals
    logic [COORD_W-1:0]   c0_clamp;
    logic [COORD_W-1:0]   c1_clamp;
    logic [COORD_W-1:0]   r0_clamp;
    logic [COORD_W-1:0]   r1_clamp;
    logic [SUM_W-1:0]     base_plus;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] new_word;
    logic [NG*8-1:0]      old_pad;
    logic [NG*8-1:0]      new_pad;
    logic [GW-1:0]        grp_old [NG];
    logic [GW-1:0]        grp_new [NG];
    logic [PW-1:0]        pop_old_sum;
    logic [PW-1:0]        pop_new_sum;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // clamp corners to the grid
    assign c0_clamp = (32'(first_column) > GRID_COLUMNS - 1) ?
                      COORD_W'(GRID_COLUMNS - 1) : first_column;
    assign c1_clamp = (32'(last_column) > GRID_COLUMNS - 1) ?
                      COORD_W'(GRID_COLUMNS - 1) : last_column;
    assign r0_clamp = (32'(first_row) > GRID_ROWS - 1) ?
                      COORD_W'(GRID_ROWS - 1) : first_row;
    assign r1_clamp = (32'(last_row) > GRID_ROWS - 1) ?
                      COORD_W'(GRID_ROWS - 1) : last_row;

    // word walk status
    assign base_plus = {1'b0, base_reg} + SUM_W'(WORD_BITS);
    assign rd_addr   = row_base_reg + AW'(word_reg);

    assign stat.clear_last = (clear_addr_reg == AW'(TOTAL_WORDS - 1));
    assign stat.in_noop    = ((command != OP_SET) && (command != OP_CLEAR) &&
                              (command != OP_INVERT)) ||
                             (c0_clamp > c1_clamp) || (r0_clamp > r1_clamp);
    assign stat.seek_done  = ({1'b0, c0_reg} < base_plus);
    assign stat.word_last  = ({1'b0, c1_reg} < base_plus);
    assign stat.row_last   = (row_reg == r1_reg);
    assign stat.pipe_busy  = s1_valid_reg || s2_valid_reg || s3_valid_reg;

    assign lit_count = lit_count_reg;

    // column mask of the current word
    always_comb
    begin
        logic [SUM_W-1:0] col;
        col  = '0;
        mask = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            col     = {1'b0, base_reg} + SUM_W'(i);
            mask[i] = (col >= {1'b0, c0_reg}) && (col <= {1'b0, c1_reg});
        end
    end

    // apply the operation to the fetched word
    always_comb
    begin
        unique case (op_reg)
            OP_SET:    new_word = rd_data_reg | s1_mask_reg;
            OP_CLEAR:  new_word = rd_data_reg & ~s1_mask_reg;
            OP_INVERT: new_word = rd_data_reg ^ s1_mask_reg;
            default:   new_word = rd_data_reg;
        endcase
    end

    // per-byte bit counts of the masked old and new words
    assign old_pad = (NG*8)'(rd_data_reg & s1_mask_reg);
    assign new_pad = (NG*8)'(new_word & s1_mask_reg);

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            grp_old[g] = '0;
            grp_new[g] = '0;
            for (int b = 0; b < 8; b++)
            begin
                grp_old[g] = grp_old[g] + GW'(old_pad[g*8+b]);
                grp_new[g] = grp_new[g] + GW'(new_pad[g*8+b]);
            end
        end
    end

    // sum of the byte counts
    always_comb
    begin
        pop_old_sum = '0;
        pop_new_sum = '0;
        for (int g = 0; g < NG; g++)
        begin
            pop_old_sum = pop_old_sum + PW'(grp_old_reg[g]);
            pop_new_sum = pop_new_sum + PW'(grp_new_reg[g]);
        end
    end

    // memory write port: clearing pass or word write-back
    assign wr_en   = dp_cmd.clear_step || s1_valid_reg;
    assign wr_addr = dp_cmd.clear_step ? clear_addr_reg : s1_addr_reg;
    assign wr_data = dp_cmd.clear_step ? '0 : new_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_reg[wr_addr] <= wr_data;
        end
        if (dp_cmd.issue)
        begin
            rd_data_reg <= bitmap_reg[rd_addr];
        end
    end

    // rectangle walk over rows and words
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            op_reg       <= command;
            c0_reg       <= c0_clamp;
            c1_reg       <= c1_clamp;
            row_reg      <= r0_clamp;
            r1_reg       <= r1_clamp;
            row_base_reg <= AW'(32'(r0_clamp) * WORDS_PER_ROW);
            base_reg     <= '0;
            word_reg     <= '0;
        end
        else if (dp_cmd.seek_step)
        begin
            if (!stat.seek_done)
            begin
                base_reg <= base_plus[COORD_W-1:0];
                word_reg <= word_reg + WW'(1);
            end
            else
            begin
                base0_reg <= base_reg;
                word0_reg <= word_reg;
            end
        end
        else if (dp_cmd.issue)
        begin
            if (stat.word_last)
            begin
                if (!stat.row_last)
                begin
                    row_reg      <= row_reg + COORD_W'(1);
                    row_base_reg <= row_base_reg + AW'(WORDS_PER_ROW);
                    word_reg     <= word0_reg;
                    base_reg     <= base0_reg;
                end
            end
            else
            begin
                word_reg <= word_reg + WW'(1);
                base_reg <= base_plus[COORD_W-1:0];
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (dp_cmd.issue)
        begin
            s1_addr_reg <= rd_addr;
            s1_mask_reg <= mask;
        end
        if (s1_valid_reg)
        begin
            for (int g = 0; g < NG; g++)
            begin
                grp_old_reg[g] <= grp_old[g];
                grp_new_reg[g] <= grp_new[g];
            end
        end
        if (s2_valid_reg)
        begin
            pop_old_reg <= pop_old_sum;
            pop_new_reg <= pop_new_sum;
        end
        if (dp_cmd.load_result)
        begin
            lit_count_reg <= count_reg;
        end
    end

    // pipeline control, clear address and running count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            clear_addr_reg <= '0;
            count_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= dp_cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (dp_cmd.clear_step)
            begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
            end
            if (s3_valid_reg)
            begin
                count_reg <= count_reg + LIT_W'(pop_new_reg) - LIT_W'(pop_old_reg);
            end
        end
    end

    // write-back never lands on the word being fetched
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && dp_cmd.issue |-> rd_addr != s1_addr_reg)
        else $error("read and write-back collide on one word");

    // every issued word touches at least one bit
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_mask_reg != '0)
        else $error("issued word has empty mask");

    // word index stays inside the row
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.issue |-> 32'(word_reg) < WORDS_PER_ROW)
        else $error("word index beyond row");

endmodule

/* hdl/bitmap_rectangle_rop_counter.sv */
// Rectangle set / clear / invert on a one-bit bitmap with a running count
// of set bits.
// Command channel: cmd_valid / cmd_stall carry command, first_column,
// first_row, last_column, last_row. Corners are inclusive and clamped to
// the grid; an empty rectangle or an unused command code changes nothing.
// Result channel: res_valid / res_stall carry lit_count, one word per
// command, the number of set bits after that command.
// After reset the bitmap memory is cleared one word a cycle, all
// GRID_ROWS * ceil(GRID_COLUMNS / WORD_BITS) words (16384 by default);
// cmd_stall stays high during that pass.
// One command is worked at a time through a single masked read-modify-write
// of one bitmap word per cycle. After acceptance the block first steps to
// the word of the first column, then works the words the rectangle covers
// row by row, then waits for the pipeline to drain before res_valid; an
// empty command goes straight to the drain and its result.
// The result sits in an output register: a stalled result holds its value,
// and the next command is accepted while it waits, but its own result is
// loaded only once the receiver takes the previous one.
module bitmap_rectangle_rop_counter #(
    parameter int GRID_COLUMNS = 1024,
    parameter int GRID_ROWS    = 1024,
    parameter int WORD_BITS    = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic [bmrc_pkg::CMD_W-1:0]   command,
    input  logic [bmrc_pkg::COORD_W-1:0] first_column,
    input  logic [bmrc_pkg::COORD_W-1:0] first_row,
    input  logic [bmrc_pkg::COORD_W-1:0] last_column,
    input  logic [bmrc_pkg::COORD_W-1:0] last_row,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [bmrc_pkg::LIT_W-1:0]   lit_count
);
    import bmrc_pkg::*;

    bmrc_cmd_t  dp_cmd;
    bmrc_stat_t stat;

    // sequencer
    bmrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .dp_cmd    (dp_cmd),
        .stat      (stat)
    );

    // bitmap memory, word walk and count
    bmrc_datapath #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .GRID_ROWS    (GRID_ROWS),
        .WORD_BITS    (WORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .first_column (first_column),
        .first_row    (first_row),
        .last_column  (last_column),
        .last_row     (last_row),
        .dp_cmd       (dp_cmd),
        .stat         (stat),
        .lit_count    (lit_count)
    );

endmodule
